// File: rtl/texture_span_shader_unit_macros.svh
// Assertion macros shared by the texture span shader RTL.
`ifndef TEXTURE_SPAN_SHADER_UNIT_MACROS_SVH
`define TEXTURE_SPAN_SHADER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define TSS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define TSS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tss_pkg.sv
// Constants and codes for the texture span shader.
package tss_pkg;

   localparam int TEX_SIDE_LOG2_DEFAULT = 6;

   localparam int FUNC_W        = 2;
   localparam int TEXEL_INDEX_W = 12;
   localparam int WORD_W        = 32;
   localparam int SCALE_W       = 9;
   localparam int CSR_INDEX_W   = 3;
   localparam int COORD_FRAC_W  = 16;

   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_RED   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_GREEN = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_BLUE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOG_COLOR   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOG_ENABLE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_U      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_V      = 3'd6;

   localparam logic [SCALE_W-1:0] SCALE_UNITY  = 9'd256;
   localparam logic [WORD_W-1:0]  STEP_U_RESET = 32'h0001_0000;

endpackage

// File: rtl/texture_span_shader_unit.sv
// Texture span shader: texel store, span coordinates, shading pipeline.
//
// Input channel (req_*): one item per handshake. func selects load texel
// (writes texel_word at texel_index), start span (loads start_u/start_v)
// or draw (emits one shaded pixel). Unused func codes are dropped.
// Result channel (rsp_*): one item per draw: pixel_word and end_of_span.
// Config channel (csr_*): always ready; write while the block is idle.
// A draw passes the texel RAM read register, then the result register.
// Throughput: one item per cycle; the two pipeline stages (texel RAM read
// register, result register) stall together while a result waits with
// rsp_ready low, and req_ready then drops until the result is taken.
// Reset: clears coordinates and pipeline valids; config registers to defaults.
// Texel RAM contents are not cleared; read only texels already loaded.
`include "texture_span_shader_unit_macros.svh"

module texture_span_shader_unit
   import tss_pkg::*;
#(
   parameter int TEX_SIDE_LOG2 = TEX_SIDE_LOG2_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [TEXEL_INDEX_W-1:0] req_texel_index,
   input  logic [WORD_W-1:0]        req_texel_word,
   input  logic [WORD_W-1:0]        req_start_u,
   input  logic [WORD_W-1:0]        req_start_v,
   input  logic                     req_last_pixel,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [WORD_W-1:0]        rsp_pixel_word,
   output logic                     rsp_end_of_span,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [WORD_W-1:0]        csr_data
);

   localparam int TEX_ADDR_W = 2 * TEX_SIDE_LOG2;
   localparam int TEX_WORDS  = 1 << TEX_ADDR_W;
   localparam int IDX_EXT_W  = (TEXEL_INDEX_W > TEX_ADDR_W) ? TEXEL_INDEX_W : TEX_ADDR_W;

   // config registers
   logic [SCALE_W-1:0] scale_red_ff, scale_green_ff, scale_blue_ff;
   logic [WORD_W-1:0]  fog_color_ff, step_u_ff, step_v_ff;
   logic               fog_enable_ff;

   logic [WORD_W-1:0]  coord_u_ff, coord_u_in;
   logic [WORD_W-1:0]  coord_v_ff, coord_v_in;

   logic [WORD_W-1:0]  texel_mem [TEX_WORDS];
   logic [WORD_W-1:0]  texel_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_last_ff;

   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  pixel_ff, pixel_in;
   logic               eos_ff;

   logic               advance, req_fire, load_fire, start_fire, draw_fire;
   logic [IDX_EXT_W-1:0]  load_idx_ext;
   logic [TEX_ADDR_W-1:0] load_addr, draw_addr;
   logic [WORD_W-1:0]     shaded;

   function automatic logic [7:0] shade(input logic [7:0] c, input logic [SCALE_W-1:0] s);
      logic [7+SCALE_W:0] prod;
      prod = c * s;
      shade = prod[7+SCALE_W:8] > 9'd255 ? 8'hFF : prod[15:8];
   endfunction

   assign advance    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = advance;
   assign req_fire   = req_valid && req_ready;
   assign load_fire  = req_fire && (req_func == FUNC_LOAD);
   assign start_fire = req_fire && (req_func == FUNC_START);
   assign draw_fire  = req_fire && (req_func == FUNC_DRAW);

   assign load_idx_ext = IDX_EXT_W'(req_texel_index);
   assign load_addr    = load_idx_ext[TEX_ADDR_W-1:0];
   assign draw_addr    = {coord_u_ff[COORD_FRAC_W +: TEX_SIDE_LOG2],
                          coord_v_ff[COORD_FRAC_W +: TEX_SIDE_LOG2]};

   // config port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_red_ff   <= SCALE_UNITY;
         scale_green_ff <= SCALE_UNITY;
         scale_blue_ff  <= SCALE_UNITY;
         fog_color_ff   <= '0;
         fog_enable_ff  <= 1'b0;
         step_u_ff      <= STEP_U_RESET;
         step_v_ff      <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCALE_RED:   scale_red_ff   <= csr_data[SCALE_W-1:0];
            CSR_SCALE_GREEN: scale_green_ff <= csr_data[SCALE_W-1:0];
            CSR_SCALE_BLUE:  scale_blue_ff  <= csr_data[SCALE_W-1:0];
            CSR_FOG_COLOR:   fog_color_ff   <= csr_data;
            CSR_FOG_ENABLE:  fog_enable_ff  <= csr_data[0];
            CSR_STEP_U:      step_u_ff      <= csr_data;
            CSR_STEP_V:      step_v_ff      <= csr_data;
            default: ;
         endcase
      end
   end

   // span coordinates
   always_comb begin
      coord_u_in = coord_u_ff;
      coord_v_in = coord_v_ff;
      priority if (start_fire) begin
         coord_u_in = req_start_u;
         coord_v_in = req_start_v;
      end else if (draw_fire) begin
         coord_u_in = coord_u_ff + step_u_ff;
         coord_v_in = coord_v_ff + step_v_ff;
      end else begin
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_u_ff <= '0;
         coord_v_ff <= '0;
      end else begin
         coord_u_ff <= coord_u_in;
         coord_v_ff <= coord_v_in;
      end
   end

   // texel RAM
   always_ff @(posedge clock) begin
      if (load_fire) begin
         texel_mem[load_addr] <= req_texel_word;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         texel_ff   <= texel_mem[draw_addr];
         s1_last_ff <= req_last_pixel;
      end
   end

   assign s1_valid_in = advance ? draw_fire : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // shading and fog
   assign shaded = {8'h00,
                    shade(texel_ff[23:16], scale_red_ff),
                    shade(texel_ff[15:8], scale_green_ff),
                    shade(texel_ff[7:0], scale_blue_ff)};
   assign pixel_in = fog_enable_ff ? shaded + fog_color_ff : shaded;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
         eos_ff   <= s1_last_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_word  = pixel_ff;
   assign rsp_end_of_span = eos_ff;

   `TSS_ASSERT_NEXT(a_draw_enters_pipe, draw_fire, s1_valid_ff, "draw item lost at stage one")
   `TSS_ASSERT_IMPL(a_rsp_from_stage, $rose(rsp_valid_ff), $past(s1_valid_ff), "result without stage one item")
   `TSS_ASSERT_NEXT(a_coord_step, draw_fire, coord_u_ff == $past(coord_u_ff) + $past(step_u_ff), "row coordinate not stepped")
   `TSS_ASSERT_NEXT(a_coord_hold, !req_fire, $stable(coord_v_ff), "column coordinate moved without item")

endmodule
